// ===== rtl/mltiq_pkg.sv =====
// Shared types, constants and arithmetic helpers of the minimum line tree.
package mltiq_pkg;

   localparam int X_BITS         = 10;
   localparam int SLOPE_BITS     = 16;
   localparam int INTERCEPT_BITS = 32;

   localparam int LEVELS  = X_BITS + 1;
   localparam int LVL_W   = $clog2(X_BITS + 1);
   localparam int DOMAIN  = 1 << X_BITS;
   localparam int HEAP_W  = X_BITS + 2;
   localparam int CMP_W   = ((X_BITS + 1) > 11) ? (X_BITS + 1) : 11;
   localparam int PROD_W  = SLOPE_BITS + X_BITS + 1;
   localparam int EVAL_W  = ((PROD_W > INTERCEPT_BITS) ? PROD_W : INTERCEPT_BITS) + 1;
   localparam int NODE_W  = 1 + SLOPE_BITS + INTERCEPT_BITS;
   localparam int OUT_W   = 40;

   localparam logic [X_BITS-1:0] X_TOP = '1;

   localparam logic [1:0] ACT_LINE  = 2'd0;
   localparam logic [1:0] ACT_SEG   = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] slope;
      logic signed [31:0] intercept;
      logic [9:0]         seg_left;
      logic [10:0]        seg_right;
      logic [9:0]         query_x;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] min_value;
      logic                    no_line;
   } rsp_type;

   typedef struct packed {
      logic                             valid;
      logic signed [SLOPE_BITS-1:0]     slope;
      logic signed [INTERCEPT_BITS-1:0] intercept;
   } node_type;

   typedef struct packed {
      logic              en;
      logic [X_BITS-1:0] addr;
   } clr_type;

   typedef struct packed {
      logic                             query;
      logic [LVL_W-1:0]                 start;
      logic signed [SLOPE_BITS-1:0]     a;
      logic signed [INTERCEPT_BITS-1:0] b;
      logic [X_BITS-1:0]                x;
      logic [X_BITS-1:0]                l;
      logic [X_BITS-1:0]                r;
      logic [X_BITS-1:0]                idx;
      logic                             found;
      logic signed [EVAL_W-1:0]         best;
   } tok_type;

   function automatic logic signed [PROD_W-1:0] mul_point(
      input logic signed [SLOPE_BITS-1:0] s,
      input logic [X_BITS-1:0]            p
   );
      logic signed [PROD_W-1:0] sa;
      logic signed [PROD_W-1:0] pa;
      sa = PROD_W'(s);
      pa = PROD_W'($signed({1'b0, p}));
      return sa * pa;
   endfunction

   function automatic logic signed [EVAL_W-1:0] add_icpt(
      input logic signed [PROD_W-1:0]         p,
      input logic signed [INTERCEPT_BITS-1:0] b
   );
      logic signed [EVAL_W-1:0] pe;
      logic signed [EVAL_W-1:0] be;
      pe = EVAL_W'(p);
      be = EVAL_W'(b);
      return pe + be;
   endfunction

endpackage

// ===== rtl/mltiq_ram.sv =====
// Generic single-write, single-read memory with registered read data.
module mltiq_ram #(
   parameter int ADDR_W = 1,
   parameter int WIDTH  = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/mltiq_cell.sv =====
// One tree level: reads its node, evaluates both lines and hands the word down.
module mltiq_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [mltiq_pkg::LVL_W-1:0]  level,
   input  mltiq_pkg::clr_type           clr,
   input  logic                         in_valid,
   input  mltiq_pkg::tok_type           in_tok,
   output logic                         out_valid,
   output mltiq_pkg::tok_type           out_tok,
   output logic                         done,
   output logic                         ram_we,
   output logic [mltiq_pkg::X_BITS-1:0] ram_waddr,
   output logic [mltiq_pkg::NODE_W-1:0] ram_wdata,
   output logic [mltiq_pkg::X_BITS-1:0] ram_raddr,
   input  logic [mltiq_pkg::NODE_W-1:0] ram_rdata
);

   logic                v1_ff;
   mltiq_pkg::tok_type  tok1_ff;
   mltiq_pkg::node_type node1;
   logic [mltiq_pkg::X_BITS:0]   sum1;
   logic [mltiq_pkg::X_BITS-1:0] mid1;
   logic [mltiq_pkg::X_BITS-1:0] pmid1;

   logic                v2_ff;
   mltiq_pkg::tok_type  tok2_ff;
   logic                nv2_ff;
   logic signed [mltiq_pkg::SLOPE_BITS-1:0]     na2_ff;
   logic signed [mltiq_pkg::INTERCEPT_BITS-1:0] nb2_ff;
   logic [mltiq_pkg::X_BITS-1:0] mid2_ff;
   logic                xleft2_ff;
   logic signed [mltiq_pkg::PROD_W-1:0] pnl_ff, pnm_ff, pnr_ff;
   logic signed [mltiq_pkg::PROD_W-1:0] pwl_ff, pwm_ff, pwr_ff;

   logic signed [mltiq_pkg::EVAL_W-1:0] nl, nm, nr, wl, wm, wr;
   logic                put;
   logic                steer_left;
   logic                wr_en;
   mltiq_pkg::node_type wnode;

   logic                out_valid_ff, out_valid_in;
   mltiq_pkg::tok_type  out_tok_ff, out_tok_in;
   logic                done_ff, done_in;

   assign ram_raddr = in_tok.idx;
   assign node1     = ram_rdata;
   assign sum1      = {1'b0, tok1_ff.l} + {1'b0, tok1_ff.r};
   assign mid1      = sum1[mltiq_pkg::X_BITS:1];
   assign pmid1     = tok1_ff.query ? tok1_ff.x : mid1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         out_valid_ff <= out_valid_in;
         done_ff <= done_in;
      end
      tok1_ff   <= in_tok;
      tok2_ff   <= tok1_ff;
      nv2_ff    <= node1.valid;
      na2_ff    <= node1.slope;
      nb2_ff    <= node1.intercept;
      mid2_ff   <= mid1;
      xleft2_ff <= tok1_ff.x <= mid1;
      pnl_ff    <= mltiq_pkg::mul_point(node1.slope, tok1_ff.l);
      pnm_ff    <= mltiq_pkg::mul_point(node1.slope, pmid1);
      pnr_ff    <= mltiq_pkg::mul_point(node1.slope, tok1_ff.r);
      pwl_ff    <= mltiq_pkg::mul_point(tok1_ff.a, tok1_ff.l);
      pwm_ff    <= mltiq_pkg::mul_point(tok1_ff.a, pmid1);
      pwr_ff    <= mltiq_pkg::mul_point(tok1_ff.a, tok1_ff.r);
      out_tok_ff <= out_tok_in;
   end

   assign nl  = mltiq_pkg::add_icpt(pnl_ff, nb2_ff);
   assign nm  = mltiq_pkg::add_icpt(pnm_ff, nb2_ff);
   assign nr  = mltiq_pkg::add_icpt(pnr_ff, nb2_ff);
   assign wl  = mltiq_pkg::add_icpt(pwl_ff, tok2_ff.b);
   assign wm  = mltiq_pkg::add_icpt(pwm_ff, tok2_ff.b);
   assign wr  = mltiq_pkg::add_icpt(pwr_ff, tok2_ff.b);
   assign put = !tok2_ff.query && (level >= tok2_ff.start);

   always_comb begin
      out_valid_in = 1'b0;
      out_tok_in   = tok2_ff;
      done_in      = 1'b0;
      wr_en        = 1'b0;
      wnode        = '{valid: 1'b1, slope: tok2_ff.a, intercept: tok2_ff.b};
      steer_left   = xleft2_ff;
      if (v2_ff) begin
         if (tok2_ff.query) begin
            if (nv2_ff && (!tok2_ff.found || nm < tok2_ff.best)) begin
               out_tok_in.best = nm;
            end
            out_tok_in.found = tok2_ff.found | nv2_ff;
            out_valid_in = 1'b1;
         end else if (!put) begin
            if (nv2_ff && nl <= wl && nr <= wr) begin
               done_in = 1'b1;
            end else begin
               out_valid_in = 1'b1;
            end
         end else if (!nv2_ff) begin
            wr_en   = 1'b1;
            done_in = 1'b1;
         end else if (nl <= wl && nr <= wr) begin
            done_in = 1'b1;
         end else if (nl >= wl && nr >= wr) begin
            wr_en   = 1'b1;
            done_in = 1'b1;
         end else if (tok2_ff.l >= tok2_ff.r) begin
            done_in = 1'b1;
         end else begin
            out_valid_in = 1'b1;
            if (nm > wm) begin
               wr_en        = 1'b1;
               out_tok_in.a = na2_ff;
               out_tok_in.b = nb2_ff;
               steer_left   = nl < wl;
            end else begin
               steer_left   = wl < nl;
            end
         end
      end
      out_tok_in.idx = {tok2_ff.idx[mltiq_pkg::X_BITS-2:0], !steer_left};
      if (steer_left) begin
         out_tok_in.r = mid2_ff;
      end else begin
         out_tok_in.l = mid2_ff + 1'b1;
      end
   end

   assign ram_we    = clr.en | wr_en;
   assign ram_waddr = clr.en ? clr.addr : tok2_ff.idx;
   assign ram_wdata = clr.en ? '0 : wnode;

   assign out_valid = out_valid_ff;
   assign out_tok   = out_tok_ff;
   assign done      = done_ff;

endmodule

// ===== rtl/min_line_tree_insert_query.sv =====
// Top level of the minimum line tree: control, segment walk and the chain of level cells.
// A tree of 2^(X_BITS+1)-1 nodes over x in 0..2^X_BITS-1, one cell per level, each level
// in its own memory. After reset the block clears the memories before it takes the first
// word. A line insert or a query sends one word from the root to the leaves; an insert that
// settles early finishes sooner. A segment insert walks the segment's bounds one level per
// cycle while it sends no word down, and sends one word down from the root for each
// covering node, at most 2*X_BITS of them. A query gives one result word with the least
// value over the lines on the path of x, or no_line when there is none; inserts give none.
// A finished result waits in the output register while the next word is taken.
module min_line_tree_insert_query (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mltiq_pkg::req_type req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mltiq_pkg::rsp_type rsp_word
);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_ENUM   = 5'b00100,
      ST_BUSY   = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

   localparam int XB = mltiq_pkg::X_BITS;
   localparam int LV = mltiq_pkg::LEVELS;
   localparam int HW = mltiq_pkg::HEAP_W;
   localparam int CW = mltiq_pkg::CMP_W;

   state_type state_ff, state_in;
   logic [XB-1:0] clr_cnt_ff, clr_cnt_in;
   logic launch_valid_ff, launch_valid_in;
   mltiq_pkg::tok_type launch_tok_ff, launch_tok_in;
   logic seg_ff, seg_in;
   logic query_ff, query_in;
   logic [HW-1:0] lidx_ff, lidx_in, ridx_ff, ridx_in;
   logic [mltiq_pkg::LVL_W-1:0] lev_ff, lev_in;
   logic signed [mltiq_pkg::SLOPE_BITS-1:0] line_a_ff, line_a_in;
   logic signed [mltiq_pkg::INTERCEPT_BITS-1:0] line_b_ff, line_b_in;
   logic res_found_ff, res_found_in;
   logic signed [mltiq_pkg::EVAL_W-1:0] res_best_ff, res_best_in;
   logic rsp_valid_ff, rsp_valid_in;
   mltiq_pkg::rsp_type rsp_word_ff, rsp_word_in;

   mltiq_pkg::clr_type clr;
   logic chain_valid [LV+1];
   mltiq_pkg::tok_type chain_tok [LV+1];
   logic [LV-1:0] done_vec;
   logic finish;
   logic accept;

   logic [CW-1:0] lo_w, end_w, hi1_w;
   logic [HW-1:0] node_h;
   logic [HW-1:0] tgt_wide;
   logic [mltiq_pkg::LVL_W-1:0] shamt;
   logic [XB-1:0] qx;
   mltiq_pkg::tok_type base_tok;

   assign clr.en   = state_ff == ST_CLEAR;
   assign clr.addr = clr_cnt_ff;

   assign chain_valid[0] = launch_valid_ff;
   assign chain_tok[0]   = launch_tok_ff;

   for (genvar g = 0; g < LV; g++) begin : g_level
      localparam int AW = (g == 0) ? 1 : g;
      logic ram_we;
      logic [XB-1:0] ram_waddr, ram_raddr;
      logic [mltiq_pkg::NODE_W-1:0] ram_wdata, ram_rdata;

      mltiq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .level     (mltiq_pkg::LVL_W'(g)),
         .clr       (clr),
         .in_valid  (chain_valid[g]),
         .in_tok    (chain_tok[g]),
         .out_valid (chain_valid[g+1]),
         .out_tok   (chain_tok[g+1]),
         .done      (done_vec[g]),
         .ram_we    (ram_we),
         .ram_waddr (ram_waddr),
         .ram_wdata (ram_wdata),
         .ram_raddr (ram_raddr),
         .ram_rdata (ram_rdata)
      );

      mltiq_ram #(
         .ADDR_W (AW),
         .WIDTH  (mltiq_pkg::NODE_W)
      ) u_ram (
         .clock (clock),
         .we    (ram_we),
         .waddr (ram_waddr[AW-1:0]),
         .wdata (ram_wdata),
         .raddr (ram_raddr[AW-1:0]),
         .rdata (ram_rdata)
      );
   end

   assign finish = (|done_vec) | chain_valid[LV];
   assign accept = req_valid && !req_stall;

   assign lo_w  = CW'(req_word.seg_left);
   assign hi1_w = CW'(req_word.seg_right);
   assign end_w = (hi1_w > CW'(mltiq_pkg::DOMAIN)) ? CW'(mltiq_pkg::DOMAIN) : hi1_w;
   assign qx    = XB'(req_word.query_x) & mltiq_pkg::X_TOP;
   assign node_h = lidx_ff[0] ? lidx_ff : ridx_ff - 1'b1;
   assign shamt    = mltiq_pkg::LVL_W'(XB) - lev_ff;
   assign tgt_wide = node_h << shamt;

   always_comb begin
      base_tok       = '0;
      base_tok.r     = mltiq_pkg::X_TOP;
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      launch_valid_in = 1'b0;
      launch_tok_in  = launch_tok_ff;
      seg_in         = seg_ff;
      query_in       = query_ff;
      lidx_in        = lidx_ff;
      ridx_in        = ridx_ff;
      lev_in         = lev_ff;
      line_a_in      = line_a_ff;
      line_b_in      = line_b_ff;
      res_found_in   = res_found_ff;
      res_best_in    = res_best_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == mltiq_pkg::X_TOP) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_word.action)
                  mltiq_pkg::ACT_LINE: begin
                     launch_tok_in   = base_tok;
                     launch_tok_in.a = req_word.slope;
                     launch_tok_in.b = req_word.intercept;
                     launch_valid_in = 1'b1;
                     seg_in   = 1'b0;
                     query_in = 1'b0;
                     state_in = ST_BUSY;
                  end
                  mltiq_pkg::ACT_SEG: begin
                     line_a_in = req_word.slope;
                     line_b_in = req_word.intercept;
                     lidx_in   = HW'(lo_w) + HW'(mltiq_pkg::DOMAIN);
                     ridx_in   = HW'(end_w) + HW'(mltiq_pkg::DOMAIN);
                     lev_in    = mltiq_pkg::LVL_W'(XB);
                     seg_in    = 1'b1;
                     query_in  = 1'b0;
                     if (lo_w < end_w) begin
                        state_in = ST_ENUM;
                     end
                  end
                  mltiq_pkg::ACT_QUERY: begin
                     launch_tok_in       = base_tok;
                     launch_tok_in.query = 1'b1;
                     launch_tok_in.x     = qx;
                     launch_valid_in     = 1'b1;
                     seg_in   = 1'b0;
                     query_in = 1'b1;
                     state_in = ST_BUSY;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ENUM: begin
            if (lidx_ff >= ridx_ff) begin
               state_in = ST_IDLE;
            end else if (lidx_ff[0] || ridx_ff[0]) begin
               launch_tok_in       = base_tok;
               launch_tok_in.a     = line_a_ff;
               launch_tok_in.b     = line_b_ff;
               launch_tok_in.start = lev_ff;
               launch_tok_in.x     = tgt_wide[XB-1:0];
               launch_valid_in     = 1'b1;
               state_in            = ST_BUSY;
               if (lidx_ff[0]) begin
                  lidx_in = lidx_ff + 1'b1;
               end else begin
                  ridx_in = ridx_ff - 1'b1;
               end
            end else begin
               lidx_in = lidx_ff >> 1;
               ridx_in = ridx_ff >> 1;
               lev_in  = lev_ff - 1'b1;
            end
         end
         ST_BUSY: begin
            if (finish) begin
               if (query_ff) begin
                  res_found_in = chain_tok[LV].found;
                  res_best_in  = chain_tok[LV].best;
                  state_in     = ST_RESULT;
               end else if (seg_ff) begin
                  state_in = ST_ENUM;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_word_in.no_line   = !res_found_ff;
               rsp_word_in.min_value = res_found_ff ? mltiq_pkg::OUT_W'(res_best_ff) : '0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_cnt_ff      <= '0;
         launch_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_cnt_ff      <= clr_cnt_in;
         launch_valid_ff <= launch_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      launch_tok_ff <= launch_tok_in;
      seg_ff        <= seg_in;
      query_ff      <= query_in;
      lidx_ff       <= lidx_in;
      ridx_ff       <= ridx_in;
      lev_ff        <= lev_in;
      line_a_ff     <= line_a_in;
      line_b_ff     <= line_b_in;
      res_found_ff  <= res_found_in;
      res_best_ff   <= res_best_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_one_finish: assert property (@(posedge clock) disable iff (reset)
      $onehot0({done_vec, chain_valid[LV]}))
      else $error("more than one word finished in the chain");

   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      finish |-> state_ff == ST_BUSY)
      else $error("chain finished a word while the controller was not waiting");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("result word appeared without a finished query");

   a_launch_empty: assert property (@(posedge clock) disable iff (reset)
      launch_valid_ff |-> !finish)
      else $error("word launched while another was still in the chain");

endmodule
